FILE: sv/sorted_deadline_timer_queue_defines.svh
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SDTQ_ASSERT_NOW(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("sdtq check failed");

// consequence holds in the same cycle as the antecedent
`define SDTQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sdtq check failed");

// consequence holds in the cycle after the antecedent
`define SDTQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sdtq check failed");

`endif

FILE: sv/sdtq_pkg.sv
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int TIME_W     = 48;
    localparam int ID_W       = 32;
    localparam int DELAY_W    = 32;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 3;
    localparam int MAX_EXPIRE = 16;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   id;
    } entry_t;

endpackage

FILE: sv/sdtq_ram.sv
`timescale 1ns / 1ps

module sdtq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/sorted_deadline_timer_queue.sv
`timescale 1ns / 1ps
// Deadline-ordered timer queue of up to DEPTH entries, kept sorted earliest first in one
// entry RAM (deadline and id) with a single read and a single write port. The block takes
// one request at a time and drops s_ready until it is through with that request and its
// last result is in the output register. Per request: an add on a full queue returns
// KIND_FULL; an add walks back from the tail, moving each queued entry whose deadline is
// later than the new one a place toward the tail, and writes the new entry behind any
// entry with an earlier or equal deadline; a tick reports each expired entry from the
// head, then the closing result, and when anything expired moves every remaining entry
// up to close the gap; a delete scans entries from the head, then on a hit reports
// KIND_DELETED and moves every entry behind the removed one up, on a miss reports
// KIND_NOT_FOUND. The entry RAM moves one entry at a time. A request with opcode 3 is
// taken and dropped with no result. Results wait in an output register, so a stalled
// m_ready only holds the sequencer when the next result is ready.

`include "sorted_deadline_timer_queue_defines.svh"

module sorted_deadline_timer_queue #(
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sdtq_pkg::OP_W-1:0]        s_opcode,
    input  logic [sdtq_pkg::TIME_W-1:0]      s_now_us,
    input  logic [sdtq_pkg::DELAY_W-1:0]     s_delay_us,
    input  logic [sdtq_pkg::ID_W-1:0]        s_target_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sdtq_pkg::KIND_W-1:0]      m_kind,
    output logic [sdtq_pkg::ID_W-1:0]        m_entry_id,
    output logic [sdtq_pkg::TIME_W-1:0]      m_wait_us,
    output logic                             m_last
);

    import sdtq_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_START   = 10'b0000000010,
        ST_ADD_RD  = 10'b0000000100,
        ST_ADD_CMP = 10'b0000001000,
        ST_TICK_RD = 10'b0000010000,
        ST_TICK_CK = 10'b0000100000,
        ST_DEL_RD  = 10'b0001000000,
        ST_DEL_CK  = 10'b0010000000,
        ST_MOV_RD  = 10'b0100000000,
        ST_MOV_WR  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [OP_W-1:0]    op_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [ID_W-1:0]    target_reg;
    logic [TIME_W-1:0]  dl_reg, dl_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_W-1:0]    idc_reg, idc_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   lim_reg, lim_next;

    logic               m_valid_reg;
    logic [KIND_W-1:0]  m_kind_reg;
    logic [ID_W-1:0]    m_entry_id_reg;
    logic [TIME_W-1:0]  m_wait_us_reg;
    logic               m_last_reg;

    logic               out_free;
    logic               emit;
    logic [KIND_W-1:0]  emit_kind;
    logic [ID_W-1:0]    emit_id;
    logic [TIME_W-1:0]  emit_wait;
    logic               emit_last;
    logic               add_done;

    logic               ram_we;
    logic [CNT_W-1:0]   ram_waddr_full;
    logic [CNT_W-1:0]   ram_raddr_full;
    entry_t             ram_wdata;
    entry_t             ram_rdata;

    logic [TIME_W:0]    add_sum;
    logic [TIME_W-1:0]  add_dl;
    logic [TIME_W-1:0]  sub_b;
    logic [TIME_W:0]    diff;
    logic               rd_later;
    logic               accept;

    sdtq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr_full[ADDR_W-1:0]),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr_full[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // saturating deadline
    assign add_sum = {1'b0, now_reg} + {{(TIME_W - DELAY_W + 1){1'b0}}, delay_reg};
    assign add_dl  = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];

    // shared subtractor: stored deadline against new deadline or current time
    assign sub_b    = (state_reg == ST_ADD_CMP) ? dl_reg : now_reg;
    assign diff     = {1'b0, ram_rdata.deadline} - {1'b0, sub_b};
    assign rd_later = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);

    always_comb begin
        state_next     = state_reg;
        dl_next        = dl_reg;
        count_next     = count_reg;
        idc_next       = idc_reg;
        ptr_next       = ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        lim_next       = lim_reg;
        emit           = 1'b0;
        emit_kind      = KIND_ADDED;
        emit_id        = '0;
        emit_wait      = '0;
        emit_last      = 1'b1;
        add_done       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr_full = ptr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr_full = ptr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                ptr_next = '0;
                case (op_reg)
                    OP_ADD: begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                emit_kind  = KIND_FULL;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            dl_next    = add_dl;
                            ptr_next   = count_reg;
                            state_next = ST_ADD_RD;
                        end
                    end
                    OP_TICK:   state_next = ST_TICK_RD;
                    OP_DELETE: state_next = ST_DEL_RD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_ADD_RD: begin
                ram_raddr_full = ptr_reg - 1'b1;
                if (ptr_reg != '0) begin
                    state_next = ST_ADD_CMP;
                end else if (out_free) begin
                    add_done = 1'b1;
                end
            end
            ST_ADD_CMP: begin
                ram_raddr_full = ptr_reg - 1'b1;
                if (rd_later) begin
                    // later entry moves one place toward the tail
                    ram_we     = 1'b1;
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_ADD_RD;
                end else if (out_free) begin
                    add_done = 1'b1;
                end
            end
            ST_TICK_RD: begin
                if (ptr_reg < count_reg) begin
                    state_next = ST_TICK_CK;
                end else if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_TICK_DONE;
                    lim_next   = count_reg;
                    wr_ptr_next = '0;
                    count_next = count_reg - ptr_reg;
                    state_next = (ptr_reg == '0) ? ST_IDLE : ST_MOV_RD;
                end
            end
            ST_TICK_CK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (!rd_later && int'(ptr_reg) < MAX_EXPIRE) begin
                        emit_kind  = KIND_EXPIRED;
                        emit_id    = ram_rdata.id;
                        emit_last  = 1'b0;
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_TICK_RD;
                    end else begin
                        emit_kind   = KIND_TICK_DONE;
                        emit_wait   = rd_later ? diff[TIME_W-1:0] : '0;
                        lim_next    = count_reg;
                        wr_ptr_next = '0;
                        count_next  = count_reg - ptr_reg;
                        state_next  = (ptr_reg == '0) ? ST_IDLE : ST_MOV_RD;
                    end
                end
            end
            ST_DEL_RD: begin
                if (ptr_reg < count_reg) begin
                    state_next = ST_DEL_CK;
                end else if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_NOT_FOUND;
                    state_next = ST_IDLE;
                end
            end
            ST_DEL_CK: begin
                if (ram_rdata.id != target_reg) begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_DEL_RD;
                end else if (out_free) begin
                    emit        = 1'b1;
                    emit_kind   = KIND_DELETED;
                    wr_ptr_next = ptr_reg;
                    ptr_next    = ptr_reg + 1'b1;
                    lim_next    = count_reg;
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_MOV_RD;
                end
            end
            ST_MOV_RD: begin
                state_next = (ptr_reg < lim_reg) ? ST_MOV_WR : ST_IDLE;
            end
            ST_MOV_WR: begin
                ram_we         = 1'b1;
                ram_waddr_full = wr_ptr_reg;
                ptr_next       = ptr_reg + 1'b1;
                wr_ptr_next    = wr_ptr_reg + 1'b1;
                state_next     = ST_MOV_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (add_done) begin
            // new entry lands behind every entry with an equal deadline
            ram_we             = 1'b1;
            ram_waddr_full     = ptr_reg;
            ram_wdata.deadline = dl_reg;
            ram_wdata.id       = idc_reg + 1'b1;
            idc_next           = idc_reg + 1'b1;
            count_next         = count_reg + 1'b1;
            emit               = 1'b1;
            emit_kind          = KIND_ADDED;
            emit_id            = idc_reg + 1'b1;
            state_next         = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idc_reg   <= idc_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_opcode;
            now_reg    <= s_now_us;
            delay_reg  <= s_delay_us;
            target_reg <= s_target_id;
        end
        dl_reg     <= dl_next;
        ptr_reg    <= ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        lim_reg    <= lim_next;
        if (emit) begin
            m_kind_reg     <= emit_kind;
            m_entry_id_reg <= emit_id;
            m_wait_us_reg  <= emit_wait;
            m_last_reg     <= emit_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_entry_id = m_entry_id_reg;
    assign m_wait_us  = m_wait_us_reg;
    assign m_last     = m_last_reg;

    `SDTQ_ASSERT_NOW(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `SDTQ_ASSERT_NEXT(a_add_grows, aclk, aresetn, add_done, count_reg == $past(count_reg) + 1'b1)
    `SDTQ_ASSERT_IMPLY(a_move_order, aclk, aresetn, state_reg == ST_MOV_WR, wr_ptr_reg < ptr_reg)
    `SDTQ_ASSERT_IMPLY(a_expire_range, aclk, aresetn, emit && emit_kind == KIND_EXPIRED, ptr_reg < count_reg)

endmodule

FILE: tb/sorted_deadline_timer_queue_test.sv
`timescale 1ns / 1ps

module sorted_deadline_timer_queue_test;
    import sdtq_pkg::*;

    localparam int TIMER_DEPTH = 16;
    localparam int IDLE_PCT = 21;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   entry_id;
        logic [TIME_W-1:0] wait_us;
        logic              last;
    } timer_result_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode = '0;
    logic [TIME_W-1:0]    s_now_us = '0;
    logic [DELAY_W-1:0]   s_delay_us = '0;
    logic [ID_W-1:0]      s_target_id = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [KIND_W-1:0]    m_kind;
    logic [ID_W-1:0]      m_entry_id;
    logic [TIME_W-1:0]    m_wait_us;
    logic                 m_last;

    // shadow copy of the sorted timer chain
    logic [TIME_W-1:0] shadow_deadline [TIMER_DEPTH];
    logic [ID_W-1:0]   shadow_id [TIMER_DEPTH];
    int                shadow_count = 0;
    logic [ID_W-1:0]   shadow_id_ctr = '0;
    timer_result_t     timer_results_due[$];

    bit                idle_en = 1'b1;
    logic [TIME_W-1:0] wall_us = '0;
    int                fail_count = 0;
    int                stall_cycles = 0;
    int                adds_sent = 0;
    int                ticks_sent = 0;
    int                deletes_sent = 0;
    int                expired_seen = 0;
    int                full_seen = 0;

    sorted_deadline_timer_queue #(
        .DEPTH(TIMER_DEPTH)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_now_us   (s_now_us),
        .s_delay_us (s_delay_us),
        .s_target_id(s_target_id),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_entry_id (m_entry_id),
        .m_wait_us  (m_wait_us),
        .m_last     (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void note_result(input logic [KIND_W-1:0] kind,
                                        input logic [ID_W-1:0] entry_id,
                                        input logic [TIME_W-1:0] wait_us,
                                        input logic last);
        timer_result_t r;
        r.kind = kind;
        r.entry_id = entry_id;
        r.wait_us = wait_us;
        r.last = last;
        timer_results_due.push_back(r);
    endfunction

    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_deadline[i] = shadow_deadline[i + 1];
            shadow_id[i] = shadow_id[i + 1];
        end
        shadow_count--;
    endfunction

    function automatic void predict_timer_request(input logic [OP_W-1:0] op,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic [DELAY_W-1:0] delay,
                                                  input logic [ID_W-1:0] target);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] wait_v;
        int                pos;
        int                n;
        int                i;
        bit                found;
        case (op)
            OP_ADD: begin
                if (shadow_count >= TIMER_DEPTH) begin
                    note_result(KIND_FULL, '0, '0, 1'b1);
                end else begin
                    sum = {1'b0, now} + {{(TIME_W - DELAY_W + 1){1'b0}}, delay};
                    deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    shadow_id_ctr = shadow_id_ctr + 1'b1;
                    // new entry goes behind any equal deadline
                    pos = 0;
                    while (pos < shadow_count && shadow_deadline[pos] <= deadline)
                        pos++;
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_deadline[i] = shadow_deadline[i - 1];
                        shadow_id[i] = shadow_id[i - 1];
                    end
                    shadow_deadline[pos] = deadline;
                    shadow_id[pos] = shadow_id_ctr;
                    shadow_count++;
                    note_result(KIND_ADDED, shadow_id_ctr, '0, 1'b1);
                end
            end
            OP_TICK: begin
                n = 0;
                while (shadow_count > 0 && n < MAX_EXPIRE && shadow_deadline[0] <= now) begin
                    note_result(KIND_EXPIRED, shadow_id[0], '0, 1'b0);
                    drop_entry(0);
                    n++;
                end
                wait_v = '0;
                if (shadow_count > 0 && shadow_deadline[0] > now)
                    wait_v = shadow_deadline[0] - now;
                note_result(KIND_TICK_DONE, '0, wait_v, 1'b1);
            end
            OP_DELETE: begin
                found = 1'b0;
                for (i = 0; i < shadow_count && !found; i++) begin
                    if (shadow_id[i] == target) begin
                        drop_entry(i);
                        found = 1'b1;
                    end
                end
                note_result(found ? KIND_DELETED : KIND_NOT_FOUND, '0, '0, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [TIME_W-1:0] now,
                                input logic [DELAY_W-1:0] delay,
                                input logic [ID_W-1:0] target);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_now_us <= now;
        s_delay_us <= delay;
        s_target_id <= target;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_timer_request(op, now, delay, target);
        if (op == OP_ADD) adds_sent++;
        if (op == OP_TICK) ticks_sent++;
        if (op == OP_DELETE) deletes_sent++;
    endtask

    task automatic wait_for_queue_drain();
        s_valid <= 1'b0;
        while (timer_results_due.size() != 0) @(posedge aclk);
    endtask

    // mostly current-time traffic, a few wild times and ids as noise
    task automatic send_random_request(input int add_pct);
        logic [OP_W-1:0]    op;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    target;
        logic [63:0]        wide;
        int                 pick;
        int                 rest;
        pick = $urandom_range(99);
        rest = 100 - add_pct;
        if (pick < add_pct) op = OP_ADD;
        else if (pick < add_pct + rest * 55 / 100) op = OP_TICK;
        else if (pick < add_pct + rest * 93 / 100) op = OP_DELETE;
        else op = OP_UNUSED;
        now = wall_us;
        delay = $urandom_range(0, 2000);
        target = $urandom;
        if ($urandom_range(99) < 20) delay = $urandom;
        if ($urandom_range(99) < 8) begin
            wide = {$urandom, $urandom};
            now = wide[TIME_W-1:0];
        end
        if (op == OP_DELETE && shadow_count > 0 && $urandom_range(99) < 75)
            target = shadow_id[$urandom_range(0, shadow_count - 1)];
        wall_us = wall_us + TIME_W'($urandom_range(0, 400));
        send_request(op, now, delay, target);
    endtask

    task automatic test_empty_queue();
        send_request(OP_TICK, '0, '0, '0);
        send_request(OP_UNUSED, '1, '1, '1);
    endtask

    task automatic test_add_extremes();
        // deadline saturates at the top of the time range
        send_request(OP_ADD, TIME_MAX, '1, '0);
        send_request(OP_ADD, '0, '0, '1);
    endtask

    task automatic test_equal_deadlines();
        send_request(OP_ADD, 48'd5, 32'd5, '0);
        send_request(OP_ADD, 48'd0, 32'd10, '0);
        send_request(OP_TICK, 48'd9, '0, '0);
        send_request(OP_TICK, 48'd10, '0, '0);
    endtask

    task automatic test_delete_by_id();
        logic [ID_W-1:0] victim;
        victim = shadow_id[0];
        send_request(OP_DELETE, '0, '0, victim);
        send_request(OP_DELETE, '0, '0, victim);
        send_request(OP_DELETE, '1, '0, '0);
    endtask

    task automatic test_full_queue();
        while (shadow_count < TIMER_DEPTH)
            send_request(OP_ADD, '0, $urandom_range(0, 3) == 0 ? 32'd100 : $urandom, '0);
        send_request(OP_ADD, '0, 32'd1, '0);
        // drains the whole chain in one tick, right at the per-tick bound
        send_request(OP_TICK, TIME_MAX, '0, '0);
    endtask

    task automatic test_random_traffic();
        int i;
        wall_us = 48'd1000;
        for (i = 0; i < 80; i++) send_random_request(45);
        wait_for_queue_drain();
        for (i = 0; i < 80; i++) send_random_request(70);
    endtask

    task automatic test_back_to_back();
        int i;
        idle_en = 1'b0;
        wall_us = TIME_MAX - 48'd20000;
        for (i = 0; i < 40; i++) send_random_request(50);
        idle_en = 1'b1;
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        timer_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (timer_results_due.size() == 0) begin
                $error("unexpected result: kind %0d entry_id %0d", m_kind, m_entry_id);
                fail_count++;
            end else begin
                due = timer_results_due.pop_front();
                if (m_kind !== due.kind) begin
                    $error("kind: expected %0d, actual %0d", due.kind, m_kind);
                    fail_count++;
                end
                if (m_entry_id !== due.entry_id) begin
                    $error("entry_id: expected %0d, actual %0d", due.entry_id, m_entry_id);
                    fail_count++;
                end
                if (m_wait_us !== due.wait_us) begin
                    $error("wait_us: expected %0d, actual %0d", due.wait_us, m_wait_us);
                    fail_count++;
                end
                if (m_last !== due.last) begin
                    $error("last: expected %0d, actual %0d", due.last, m_last);
                    fail_count++;
                end
                if (due.kind == KIND_EXPIRED) expired_seen++;
                if (due.kind == KIND_FULL) full_seen++;
            end
        end
    end

    // no request or result moving for too long means the block hung
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_add_extremes();
        test_equal_deadlines();
        test_delete_by_id();
        test_full_queue();
        test_random_traffic();
        test_back_to_back();
        wait_for_queue_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d adds, %0d ticks, %0d deletes with random stalls on both sides",
                 adds_sent, ticks_sent, deletes_sent);
        $display("saw %0d expirations and %0d adds rejected on a full queue",
                 expired_seen, full_seen);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/sdtq_pkg.sv
sv/sdtq_ram.sv
sv/sorted_deadline_timer_queue.sv
tb/sorted_deadline_timer_queue_test.sv
